@@ sv/checked_decimal_parser_defines.svh @@
// Assertion macros used by the checked decimal parser checker file.
`ifndef CHECKED_DECIMAL_PARSER_DEFINES_SVH
`define CHECKED_DECIMAL_PARSER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define CDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/cdp_pkg.sv @@
// Types and constants of the checked decimal parser.
`default_nettype none

package cdp_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned MAG_W      = 31;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LO = 3'd4;

    localparam logic [ADDR_W-1:0] HEAP_BYTES = 32'd4096;
    localparam logic [MAG_W-1:0]  CLAMP_MAX  = 31'h7FFF_FFFF;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Classified character handed from front to back
    typedef struct packed {
        logic       start;
        logic       addr_ok;
        logic       is_digit;
        logic       is_minus;
        logic       is_plus;
        logic [3:0] digit;
    } t_token;

endpackage

`default_nettype wire

@@ sv/cdp_in_if.sv @@
// Input channel: one character with its address per item.
`default_nettype none

interface cdp_in_if;
    logic        valid;
    logic        ready;
    logic        start_of_string;
    logic [7:0]  char_code;
    logic [31:0] byte_address;

    modport source (output valid, output start_of_string, output char_code,
                    output byte_address, input ready);
    modport sink   (input valid, input start_of_string, input char_code,
                    input byte_address, output ready);
endinterface

`default_nettype wire

@@ sv/cdp_out_if.sv @@
// Output channel: one parsed value per item.
`default_nettype none

interface cdp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] parsed_value;

    modport source (output valid, output parsed_value, input ready);
    modport sink   (input valid, input parsed_value, output ready);
endinterface

`default_nettype wire

@@ sv/checked_decimal_parser.sv @@
// Top level of the checked decimal parser.
//
//  channel   dir  handshake          payload
//  i_item    in   valid / ready      start_of_string, char_code, byte_address
//  o_result  out  valid / ready      parsed_value
//  i_cfg_*   in   i_cfg_we only      i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while results are taken; the front takes an
// item whenever the two-entry token queue has room.
// The item that ends the parse is registered in the token queue, and its
// result is then registered in the output register.
// The back advances only when the output register is empty or being taken,
// so an output stall fills the queue and then drops i_item.ready.
// Reset (i_rst_n low, synchronous) clears windows, parse state, queue and output valid.
`default_nettype none

module checked_decimal_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cdp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data,
    cdp_in_if.sink                             i_item,
    cdp_out_if.source                          o_result
);

    cdp_pkg::t_token front_token, queue_token;
    logic            push, full, queue_valid, pop;

    // classify each character and check its address against the windows
    cdp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_full     (full),
        .o_push     (push),
        .o_token    (front_token)
    );

    // decouples the front from output back-pressure
    cdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .o_full  (full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_token (queue_token)
    );

    // sign, magnitude accumulate with clamp, emit on end of parse
    cdp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_token  (queue_token),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

@@ sv/cdp_front.sv @@
// Front end: window registers, address check and character classification.
`default_nettype none

module cdp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cdp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data,
    cdp_in_if.sink                             i_item,
    input  wire logic                          i_full,
    output logic                               o_push,
    output cdp_pkg::t_token                    o_token
);

    logic [31:0] r_code_lo, r_code_hi, r_data_lo, r_data_hi, r_heap_lo;
    logic [31:0] heap_hi;
    logic        addr_ok;

    // Empty when hi == lo; bounds compare with wrapping hi - 1
    function automatic logic in_window(input logic [31:0] a, input logic [31:0] lo,
                                       input logic [31:0] hi);
        logic [31:0] hi_m1;
        hi_m1 = hi - 32'd1;
        return (hi != lo) && (a >= lo) && (a <= hi_m1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_lo <= '0;
            r_code_hi <= '0;
            r_data_lo <= '0;
            r_data_hi <= '0;
            r_heap_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cdp_pkg::REG_CODE_LO: r_code_lo <= i_cfg_data;
                cdp_pkg::REG_CODE_HI: r_code_hi <= i_cfg_data;
                cdp_pkg::REG_DATA_LO: r_data_lo <= i_cfg_data;
                cdp_pkg::REG_DATA_HI: r_data_hi <= i_cfg_data;
                cdp_pkg::REG_HEAP_LO: r_heap_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign heap_hi = r_heap_lo + cdp_pkg::HEAP_BYTES;
    assign addr_ok = in_window(i_item.byte_address, r_code_lo, r_code_hi)
                  || in_window(i_item.byte_address, r_data_lo, r_data_hi)
                  || in_window(i_item.byte_address, r_heap_lo, heap_hi);

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_token.start    = i_item.start_of_string;
        o_token.addr_ok  = addr_ok;
        o_token.is_digit = (i_item.char_code >= cdp_pkg::CHAR_ZERO)
                        && (i_item.char_code <= cdp_pkg::CHAR_NINE);
        o_token.is_minus = (i_item.char_code == cdp_pkg::CHAR_MINUS);
        o_token.is_plus  = (i_item.char_code == cdp_pkg::CHAR_PLUS);
        o_token.digit    = 4'(i_item.char_code - cdp_pkg::CHAR_ZERO);
    end

endmodule

`default_nettype wire

@@ sv/cdp_queue.sv @@
// Short token queue between front and back.
`default_nettype none

module cdp_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire cdp_pkg::t_token i_token,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_pop,
    output cdp_pkg::t_token o_token
);

    cdp_pkg::t_token                 r_mem [cdp_pkg::Q_DEPTH];
    logic [cdp_pkg::Q_PTR_W-1:0]     r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [cdp_pkg::Q_CNT_W-1:0]     r_count, n_count;
    logic                            do_push, do_pop;

    localparam logic [cdp_pkg::Q_PTR_W-1:0] LAST = cdp_pkg::Q_PTR_W'(cdp_pkg::Q_DEPTH - 1);
    localparam logic [cdp_pkg::Q_CNT_W-1:0] FULL = cdp_pkg::Q_CNT_W'(cdp_pkg::Q_DEPTH);

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

`default_nettype wire

@@ sv/cdp_back.sv @@
// Back end: parse state, digit accumulate with clamp, output register.
`default_nettype none

module cdp_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire cdp_pkg::t_token i_token,
    output logic            o_pop,
    cdp_out_if.source       o_result
);

    logic                        r_active, r_first, r_neg;
    logic                        n_active, n_first, n_neg;
    logic [cdp_pkg::MAG_W-1:0]   r_mag, n_mag;
    logic                        r_out_valid;
    logic signed [31:0]          r_out_value;

    logic                        eff_active, eff_first, eff_neg;
    logic [cdp_pkg::MAG_W-1:0]   eff_mag, emit_mag;
    logic [34:0]                 acc;
    logic                        emit;
    logic [31:0]                 mag_ext;

    // A start token restarts the parse before it is judged
    assign eff_active = i_token.start || r_active;
    assign eff_first  = i_token.start || r_first;
    assign eff_neg    = i_token.start ? 1'b0 : r_neg;
    assign eff_mag    = i_token.start ? '0 : r_mag;

    // mag * 10 + digit as shift-add
    assign acc = ({4'b0, eff_mag} << 3) + ({4'b0, eff_mag} << 1) + 35'(i_token.digit);

    assign o_pop = i_valid && (!r_out_valid || o_result.ready);

    always_comb begin
        n_active = r_active;
        n_first  = r_first;
        n_neg    = r_neg;
        n_mag    = r_mag;
        emit     = 1'b0;
        emit_mag = eff_mag;
        if (o_pop) begin
            n_active = eff_active;
            n_first  = eff_first;
            n_neg    = eff_neg;
            n_mag    = eff_mag;
            if (eff_active) begin
                if (!i_token.addr_ok) begin
                    emit = 1'b1;
                end else if (eff_first && (i_token.is_minus || i_token.is_plus)) begin
                    n_first = 1'b0;
                    n_neg   = i_token.is_minus;
                end else if (!i_token.is_digit) begin
                    emit = 1'b1;
                end else if (acc > 35'(cdp_pkg::CLAMP_MAX)) begin
                    n_mag    = cdp_pkg::CLAMP_MAX;
                    emit_mag = cdp_pkg::CLAMP_MAX;
                    emit     = 1'b1;
                end else begin
                    n_mag   = acc[cdp_pkg::MAG_W-1:0];
                    n_first = 1'b0;
                end
                if (emit) begin
                    n_active = 1'b0;
                    n_first  = 1'b0;
                end
            end
        end
    end

    assign mag_ext = {1'b0, emit_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_first     <= 1'b0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_first  <= n_first;
            r_neg    <= n_neg;
            r_mag    <= n_mag;
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_value <= eff_neg ? $signed(32'd0 - mag_ext) : $signed(mag_ext);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.parsed_value = r_out_value;

endmodule

`default_nettype wire

@@ sv/cdp_checker.sv @@
// Port-level checks of the checked decimal parser, bound to the top level.
`default_nettype none
`include "checked_decimal_parser_defines.svh"

module cdp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_value
);

    `CDP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value), "stalled result changed")
    `CDP_ASSERT(a_no_min_int, i_clk, i_rst_n, i_out_valid |-> i_out_value != 32'h8000_0000, "result outside clamp range")
    `CDP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind checked_decimal_parser cdp_checker u_cdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.parsed_value)
);

`default_nettype wire
